/* src/btl_pkg.sv */
// ----------------------------------------------------------------------------
// btl_pkg
// Types and fixed constants shared by the strength update block: payload
// structs, controller command and status groups, widths and status codes.
// ----------------------------------------------------------------------------
package btl_pkg;

    // Fixed widths of the arithmetic
    localparam int SUM_W       = 60;   // reciprocal sum, 32 fractional bits
    localparam int DEN_W       = 61;   // rate * 2^32 + reciprocal sum
    localparam int WIN_W       = 11;   // win counter
    localparam int NUM_W       = 12;   // shape - 1 + wins
    localparam int RECIP_FRAC  = 32;   // fractional bits of one reciprocal
    localparam int FINAL_STEPS = 32;   // quotient bits of the final division
    localparam int WIN_MAX     = 2047;

    typedef logic [31:0]        lambda_t;
    typedef logic [32:0]        ssum_t;
    typedef logic [SUM_W-1:0]   sum_t;
    typedef logic [DEN_W-1:0]   den_t;
    typedef logic [WIN_W-1:0]   win_t;
    typedef logic [NUM_W-1:0]   num_t;
    typedef logic [7:0]         cfg_t;
    typedef logic [1:0]         status_t;
    typedef logic               cfg_idx_t;

    // Result status codes
    localparam status_t ST_OK   = 2'd0;
    localparam status_t ST_SAT  = 2'd1;
    localparam status_t ST_DIV0 = 2'd2;

    // Configuration register indexes
    localparam cfg_idx_t CFG_SHAPE = 1'b0;
    localparam cfg_idx_t CFG_RATE  = 1'b1;

    localparam lambda_t LAMBDA_MAX = 32'hFFFF_FFFF;

    // One comparison record
    typedef struct packed {
        logic    choose;
        lambda_t opponent_lambda;
        lambda_t own_lambda;
        logic    last;
    } item_t;

    // One updated strength
    typedef struct packed {
        lambda_t new_lambda;
        status_t status;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic load_item;
        logic mark_zero;
        logic div_recip;
        logic acc;
        logic load_den;
        logic div_final;
        logic emit_err;
        logic emit_sat;
        logic emit_ok;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic s_zero;
        logic s_one;
        logic last;
        logic div_done;
        logic no_divide;
        logic r0_ge_den;
    } dp_status_t;

endpackage

/* src/btl_div.sv */
// ----------------------------------------------------------------------------
// btl_div
// Shared radix-2 restoring divider. Loads a remainder below the divisor and
// shifts in zero bits, one quotient bit per cycle, for a given step count.
// ----------------------------------------------------------------------------
module btl_div #(
    parameter int QW = 48,
    parameter int CW = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [CW-1:0]       steps,
    input  btl_pkg::den_t       rem_init,
    input  btl_pkg::den_t       divisor,
    output logic                done,
    output logic [QW-1:0]       quo
);

    logic                running_reg, running_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    btl_pkg::den_t       rem_reg, rem_next;
    btl_pkg::den_t       div_reg, div_next;
    logic [QW-1:0]       quo_reg, quo_next;
    logic [btl_pkg::DEN_W:0] shifted;
    logic [btl_pkg::DEN_W:0] diff;

    // Trial subtract of the doubled remainder
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        diff    = shifted - {1'b0, div_reg};
    end

    // Advance one quotient bit per cycle
    always_comb
    begin
        running_next = running_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        div_next     = div_reg;
        quo_next     = quo_reg;
        if (start)
        begin
            running_next = 1'b1;
            cnt_next     = steps;
            rem_next     = rem_init;
            div_next     = divisor;
            quo_next     = '0;
        end
        else if (running_reg)
        begin
            if (shifted >= {1'b0, div_reg})
            begin
                rem_next = diff[btl_pkg::DEN_W-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[btl_pkg::DEN_W-1:0];
                quo_next = {quo_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                running_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        div_reg <= div_next;
        quo_reg <= quo_next;
    end

    // Last step runs in this cycle; quotient is ready on the next
    assign done = running_reg && (cnt_reg == CW'(1));
    assign quo  = quo_reg;

endmodule

/* src/btl_dp.sv */
// ----------------------------------------------------------------------------
// btl_dp
// Datapath: configuration registers, record registers, win counter,
// saturating reciprocal sum, final operands and the result register.
// ----------------------------------------------------------------------------
module btl_dp #(
    parameter int MAX_HITS         = 1024,
    parameter int LAMBDA_FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  btl_pkg::cfg_idx_t     cfg_index,
    input  btl_pkg::cfg_t         cfg_data,
    input  btl_pkg::item_t        item,
    input  btl_pkg::ctrl_cmd_t    cmd,
    output btl_pkg::dp_status_t   sts,
    output btl_pkg::result_t      result,
    output logic                  result_valid
);

    localparam int QW = LAMBDA_FRAC_BITS + btl_pkg::RECIP_FRAC;
    localparam int CW = $clog2(QW + 1);
    localparam btl_pkg::win_t WIN_CAP =
        btl_pkg::win_t'((MAX_HITS < btl_pkg::WIN_MAX) ? MAX_HITS : btl_pkg::WIN_MAX);

    btl_pkg::cfg_t    shape_reg, shape_next;
    btl_pkg::cfg_t    rate_reg, rate_next;
    btl_pkg::win_t    win_reg, win_next;
    btl_pkg::sum_t    sum_reg, sum_next;
    logic             zero_seen_reg, zero_seen_next;
    logic             valid_reg, valid_next;
    btl_pkg::ssum_t   s_reg;
    logic             last_reg;
    btl_pkg::den_t    den_reg;
    btl_pkg::num_t    num_reg;
    btl_pkg::result_t result_reg, result_next;

    btl_pkg::cfg_t    shape_m1;
    btl_pkg::num_t    num_calc;
    btl_pkg::den_t    r0;
    btl_pkg::den_t    sum_ext;
    logic [QW:0]      term;
    logic             div_start;
    logic [CW-1:0]    div_steps;
    btl_pkg::den_t    div_rem_init;
    btl_pkg::den_t    div_divisor;
    logic             div_done;
    logic [QW-1:0]    div_quo;

    // Shared divider
    btl_div #(
        .QW (QW),
        .CW (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .steps    (div_steps),
        .rem_init (div_rem_init),
        .divisor  (div_divisor),
        .done     (div_done),
        .quo      (div_quo)
    );

    // Select divider operands: reciprocal of the strength sum or final quotient
    always_comb
    begin
        r0        = btl_pkg::den_t'(num_reg) << LAMBDA_FRAC_BITS;
        div_start = cmd.div_recip || cmd.div_final;
        if (cmd.div_final)
        begin
            div_steps    = CW'(btl_pkg::FINAL_STEPS);
            div_rem_init = r0;
            div_divisor  = den_reg;
        end
        else
        begin
            div_steps    = CW'(QW);
            div_rem_init = btl_pkg::den_t'(1);
            div_divisor  = btl_pkg::den_t'(s_reg);
        end
    end

    // Reciprocal term and saturating accumulate
    always_comb
    begin
        term    = (s_reg == btl_pkg::ssum_t'(1)) ? {1'b1, {QW{1'b0}}} : {1'b0, div_quo};
        sum_ext = btl_pkg::den_t'(sum_reg) + btl_pkg::den_t'(term);
    end

    // Numerator: shape zero counts as one
    always_comb
    begin
        shape_m1 = (shape_reg == '0) ? '0 : shape_reg - btl_pkg::cfg_t'(1);
        num_calc = btl_pkg::num_t'(win_reg) + btl_pkg::num_t'(shape_m1);
    end

    // Next-state of configuration, accumulators and result
    always_comb
    begin
        shape_next     = shape_reg;
        rate_next      = rate_reg;
        win_next       = win_reg;
        sum_next       = sum_reg;
        zero_seen_next = zero_seen_reg;
        valid_next     = 1'b0;
        result_next    = result_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                btl_pkg::CFG_SHAPE: shape_next = cfg_data;
                btl_pkg::CFG_RATE:  rate_next  = cfg_data;
                default: ;
            endcase
        end

        if (cmd.load_item && item.choose && (win_reg < WIN_CAP))
        begin
            win_next = win_reg + btl_pkg::win_t'(1);
        end
        if (cmd.mark_zero)
        begin
            zero_seen_next = 1'b1;
        end
        if (cmd.acc)
        begin
            sum_next = sum_ext[btl_pkg::SUM_W] ? '1 : sum_ext[btl_pkg::SUM_W-1:0];
        end

        if (cmd.emit_err || cmd.emit_sat || cmd.emit_ok)
        begin
            valid_next     = 1'b1;
            win_next       = '0;
            sum_next       = '0;
            zero_seen_next = 1'b0;
            if (cmd.emit_err)
            begin
                result_next.new_lambda = '0;
                result_next.status     = btl_pkg::ST_DIV0;
            end
            else if (cmd.emit_sat)
            begin
                result_next.new_lambda = btl_pkg::LAMBDA_MAX;
                result_next.status     = btl_pkg::ST_SAT;
            end
            else
            begin
                result_next.new_lambda = div_quo[31:0];
                result_next.status     = btl_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_reg     <= btl_pkg::cfg_t'(1);
            rate_reg      <= btl_pkg::cfg_t'(1);
            win_reg       <= '0;
            sum_reg       <= '0;
            zero_seen_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else
        begin
            shape_reg     <= shape_next;
            rate_reg      <= rate_next;
            win_reg       <= win_next;
            sum_reg       <= sum_next;
            zero_seen_reg <= zero_seen_next;
            valid_reg     <= valid_next;
        end
    end

    // Hold record, final operands and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            s_reg    <= btl_pkg::ssum_t'(item.own_lambda) + btl_pkg::ssum_t'(item.opponent_lambda);
            last_reg <= item.last;
        end
        if (cmd.load_den)
        begin
            den_reg <= (btl_pkg::den_t'(rate_reg) << btl_pkg::RECIP_FRAC)
                       + btl_pkg::den_t'(sum_reg);
            num_reg <= num_calc;
        end
        result_reg <= result_next;
    end

    // Status towards the controller
    always_comb
    begin
        sts.s_zero    = (s_reg == '0);
        sts.s_one     = (s_reg == btl_pkg::ssum_t'(1));
        sts.last      = last_reg;
        sts.div_done  = div_done;
        sts.no_divide = zero_seen_reg || (den_reg == '0);
        sts.r0_ge_den = (r0 >= den_reg);
    end

    assign result       = result_reg;
    assign result_valid = valid_reg;

endmodule

/* src/btl_ctrl.sv */
// ----------------------------------------------------------------------------
// btl_ctrl
// Controller: sequences one record through reciprocal and accumulate, and on
// the last record through the final division and result transfer.
// ----------------------------------------------------------------------------
module btl_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  btl_pkg::dp_status_t   sts,
    output btl_pkg::ctrl_cmd_t    cmd,
    output logic                  busy
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHECK = 4'd1;
    localparam logic [3:0] S_RECIP = 4'd2;
    localparam logic [3:0] S_ACCUM = 4'd3;
    localparam logic [3:0] S_NEXT  = 4'd4;
    localparam logic [3:0] S_LDDEN = 4'd5;
    localparam logic [3:0] S_TEST  = 4'd6;
    localparam logic [3:0] S_FINAL = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;

    logic [3:0] state_reg, state_next;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (sts.s_zero)
                begin
                    cmd.mark_zero = 1'b1;
                    state_next    = S_NEXT;
                end
                else if (sts.s_one)
                begin
                    state_next = S_ACCUM;
                end
                else
                begin
                    cmd.div_recip = 1'b1;
                    state_next    = S_RECIP;
                end
            end
            S_RECIP:
            begin
                if (sts.div_done)
                begin
                    state_next = S_ACCUM;
                end
            end
            S_ACCUM:
            begin
                cmd.acc    = 1'b1;
                state_next = S_NEXT;
            end
            S_NEXT:
            begin
                state_next = sts.last ? S_LDDEN : S_IDLE;
            end
            S_LDDEN:
            begin
                cmd.load_den = 1'b1;
                state_next   = S_TEST;
            end
            S_TEST:
            begin
                if (sts.no_divide)
                begin
                    cmd.emit_err = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (sts.r0_ge_den)
                begin
                    cmd.emit_sat = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                begin
                    cmd.div_final = 1'b1;
                    state_next    = S_FINAL;
                end
            end
            S_FINAL:
            begin
                if (sts.div_done)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit_ok = 1'b1;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* src/bradley_terry_lambda_update.sv */
// ----------------------------------------------------------------------------
// bradley_terry_lambda_update
// Sequencing: a record runs an F+32-step reciprocal division (F =
// LAMBDA_FRAC_BITS) on the shared radix-2 divider; a zero or unit sum skips
// it. The last record adds a 32-step final division unless error or saturation.
// Throughput: one record per busy period; the result strobe lasts one cycle.
// Reset: priors return to 1, win count and reciprocal sum clear at once.
// ----------------------------------------------------------------------------
module bradley_terry_lambda_update #(
    parameter int MAX_HITS         = 1024,
    parameter int LAMBDA_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  btl_pkg::cfg_idx_t   cfg_index,
    input  btl_pkg::cfg_t       cfg_data,
    input  logic                start,
    input  btl_pkg::item_t      item,
    output logic                busy,
    output logic                result_valid,
    output btl_pkg::result_t    result
);

    btl_pkg::ctrl_cmd_t  cmd;
    btl_pkg::dp_status_t sts;

    // Sequence control
    btl_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Arithmetic and state
    btl_dp #(
        .MAX_HITS         (MAX_HITS),
        .LAMBDA_FRAC_BITS (LAMBDA_FRAC_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result       (result),
        .result_valid (result_valid)
    );

endmodule
